FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file trs_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/core/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants of the task restart supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int OK_CODES    = 3;
    localparam int OK_CODE_REGS = 3;

    localparam logic [8:0] MAX_WORKERS_W = 9'(MAX_WORKERS);
    localparam logic [4:0] SIGKILL       = 5'd9;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_SETTLE_TICKS  = 3'd0;
    localparam logic [2:0] CFG_MAX_RETRIES   = 3'd1;
    localparam logic [2:0] CFG_RESTART_MODE  = 3'd2;
    localparam logic [2:0] CFG_STOP_SIGNAL   = 3'd3;
    localparam logic [2:0] CFG_OK_CODE_COUNT = 3'd4;
    localparam logic [2:0] CFG_OK_CODE_0     = 3'd5;
    localparam logic [2:0] CFG_OK_CODE_1     = 3'd6;
    localparam logic [2:0] CFG_OK_CODE_2     = 3'd7;

    // restart policy codes
    localparam logic [1:0] RESTART_NEVER      = 2'd0;
    localparam logic [1:0] RESTART_UNEXPECTED = 2'd1;
    localparam logic [1:0] RESTART_ALWAYS     = 2'd2;

    typedef enum logic [2:0] {
        CMD_START        = 3'd0,
        CMD_STOP         = 3'd1,
        CMD_RESTART      = 3'd2,
        CMD_TICK         = 3'd3,
        CMD_WORKER_ENDED = 3'd4,
        CMD_START_FAILED = 3'd5
    } command_t;

    typedef enum logic [2:0] {
        ST_STOPPED  = 3'd0,
        ST_STARTING = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_EXITED   = 3'd3,
        ST_FATAL    = 3'd4,
        ST_ERROR    = 3'd5
    } group_state_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_START_ALL    = 3'd1,
        ACT_KILL_ALL     = 3'd2,
        ACT_KILL_START   = 3'd3,
        ACT_START_ONE    = 3'd4,
        ACT_STOP_DEFAULT = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REF_ACCEPTED = 2'd0,
        REF_IN_ERROR = 2'd1,
        REF_STARTED  = 2'd2
    } refusal_t;

endpackage

`default_nettype wire

FILE: rtl/core/task_restart_supervisor_top.sv
// ----------------------------------------------------------------------------
// task_restart_supervisor_top
// Lifecycle supervisor for a group of workers: start/stop/restart/tick and
// worker events in, one action result out for every event.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  in        in_valid, in_stall, command, worker_index,  event in
//            exited_by_code, exit_code
//  out       out_valid, out_stall, group_state, action,  result out
//            action_signal, action_worker, refusal, tries_now
//  cfg       cfg_write, cfg_index, cfg_data               register write
//
//  one transaction per cycle sustained while the output is not stalled; an accepted
//  input goes to the input register, then the decision logic and result register
//  the group state, try count and tick count update as a transaction moves
//  into the result register, so consecutive transactions see each other
//  rst_n clears state to stopped with zero counts and loads register defaults
//  out_stall holds the result register; the input register still fills, and
//  in_stall rises only when both registers are full and the output is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module task_restart_supervisor_top
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       command,
    input  wire logic [3:0]                       worker_index,
    input  wire logic                             exited_by_code,
    input  wire logic [7:0]                       exit_code,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [2:0]                            group_state,
    output logic [2:0]                            action,
    output logic [4:0]                            action_signal,
    output logic [3:0]                            action_worker,
    output logic [1:0]                            refusal,
    output logic [7:0]                            tries_now,

    input  wire logic                             cfg_write,
    input  wire logic [trs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [trs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int OK_CODE_HITS_W = trs_pkg::OK_CODE_REGS;

    // configuration registers
    logic [15:0] settle_ticks_reg;
    logic [7:0]  max_retries_reg;
    logic [1:0]  restart_mode_reg;
    logic [4:0]  stop_signal_reg;
    logic [1:0]  ok_code_count_reg;
    logic [7:0]  ok_code_reg [trs_pkg::OK_CODE_REGS];

    // input register
    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [3:0]  worker_reg;
    logic        by_code_reg;
    logic [7:0]  code_reg;

    // group state
    trs_pkg::group_state_t mode_reg, mode_next;
    logic [7:0]  tries_reg, tries_next;
    logic [15:0] elapsed_reg, elapsed_next;

    // result register
    logic                  out_valid_reg;
    trs_pkg::group_state_t res_state_reg;
    trs_pkg::action_t      res_action_reg, action_next;
    logic [4:0]            res_signal_reg, signal_next;
    logic [3:0]            res_worker_reg, worker_next;
    trs_pkg::refusal_t     res_refusal_reg, refusal_next;
    logic [7:0]            res_tries_reg;

    logic        advance;
    logic        fire;
    logic        active;
    logic        worker_ok;
    logic [15:0] elapsed_inc;
    logic        tick_settles;
    logic        end_settles;
    logic        retry_ok;
    logic        exit_ok;
    logic        restart_one;
    logic [OK_CODE_HITS_W-1:0] code_hit;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg  <= 16'd1;
            max_retries_reg   <= 8'd3;
            restart_mode_reg  <= trs_pkg::RESTART_UNEXPECTED;
            stop_signal_reg   <= 5'd15;
            ok_code_count_reg <= 2'd1;
            for (int i = 0; i < trs_pkg::OK_CODE_REGS; i++)
            begin
                ok_code_reg[i] <= 8'd0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                trs_pkg::CFG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_data[15:0];
                trs_pkg::CFG_MAX_RETRIES:   max_retries_reg   <= cfg_data[7:0];
                trs_pkg::CFG_RESTART_MODE:  restart_mode_reg  <= cfg_data[1:0];
                trs_pkg::CFG_STOP_SIGNAL:   stop_signal_reg   <= cfg_data[4:0];
                trs_pkg::CFG_OK_CODE_COUNT: ok_code_count_reg <= cfg_data[1:0];
                trs_pkg::CFG_OK_CODE_0:     ok_code_reg[0]    <= cfg_data[7:0];
                trs_pkg::CFG_OK_CODE_1:     ok_code_reg[1]    <= cfg_data[7:0];
                trs_pkg::CFG_OK_CODE_2:     ok_code_reg[2]    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg     <= command;
            worker_reg  <= worker_index;
            by_code_reg <= exited_by_code;
            code_reg    <= exit_code;
        end
    end

    // ------------------------------------------------------------------
    // shared decode
    // ------------------------------------------------------------------
    assign active      = (mode_reg == trs_pkg::ST_STARTING) ||
                         (mode_reg == trs_pkg::ST_RUNNING);
    assign worker_ok   = {5'd0, worker_reg} < trs_pkg::MAX_WORKERS_W;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    // tick counts first, then checks; an ended worker checks the count as it is
    assign tick_settles = (mode_reg == trs_pkg::ST_STARTING) &&
                          (elapsed_inc >= settle_ticks_reg);
    assign end_settles  = (mode_reg == trs_pkg::ST_STARTING) &&
                          (elapsed_reg >= settle_ticks_reg);
    assign retry_ok     = tries_reg < max_retries_reg;

    always_comb
    begin
        for (int i = 0; i < OK_CODE_HITS_W; i++)
        begin
            code_hit[i] = (i < int'(ok_code_count_reg)) && (i < trs_pkg::OK_CODES) &&
                          (ok_code_reg[i] == code_reg);
        end
    end

    assign exit_ok     = by_code_reg && (|code_hit);
    assign restart_one = (restart_mode_reg == trs_pkg::RESTART_ALWAYS) ||
                         ((restart_mode_reg == trs_pkg::RESTART_UNEXPECTED) && !exit_ok);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next    = mode_reg;
        tries_next   = tries_reg;
        elapsed_next = elapsed_reg;
        unique case (cmd_reg)
            trs_pkg::CMD_START:
            begin
                if (!active && (mode_reg != trs_pkg::ST_ERROR))
                begin
                    mode_next    = trs_pkg::ST_STARTING;
                    tries_next   = 8'd1;
                    elapsed_next = 16'd0;
                end
            end
            trs_pkg::CMD_STOP:
            begin
                mode_next    = trs_pkg::ST_STOPPED;
                tries_next   = 8'd0;
                elapsed_next = 16'd0;
            end
            trs_pkg::CMD_RESTART:
            begin
                mode_next    = trs_pkg::ST_STARTING;
                tries_next   = 8'd1;
                elapsed_next = 16'd0;
            end
            trs_pkg::CMD_TICK:
            begin
                if (active)
                begin
                    elapsed_next = elapsed_inc;
                    if (tick_settles)
                    begin
                        mode_next = trs_pkg::ST_RUNNING;
                    end
                end
            end
            trs_pkg::CMD_WORKER_ENDED:
            begin
                if (active && worker_ok)
                begin
                    if ((mode_reg == trs_pkg::ST_STARTING) && !end_settles)
                    begin
                        if (retry_ok)
                        begin
                            tries_next   = tries_reg + 8'd1;
                            elapsed_next = 16'd0;
                        end
                        else
                        begin
                            mode_next = trs_pkg::ST_FATAL;
                        end
                    end
                    else if (!restart_one)
                    begin
                        mode_next = trs_pkg::ST_EXITED;
                    end
                    else
                    begin
                        mode_next = trs_pkg::ST_RUNNING;
                    end
                end
            end
            trs_pkg::CMD_START_FAILED:
            begin
                if (mode_reg == trs_pkg::ST_STARTING)
                begin
                    mode_next = trs_pkg::ST_ERROR;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result fields
    // ------------------------------------------------------------------
    always_comb
    begin
        action_next  = trs_pkg::ACT_NONE;
        signal_next  = 5'd0;
        worker_next  = 4'd0;
        refusal_next = trs_pkg::REF_ACCEPTED;
        unique case (cmd_reg)
            trs_pkg::CMD_START:
            begin
                if (mode_reg == trs_pkg::ST_ERROR)
                begin
                    refusal_next = trs_pkg::REF_IN_ERROR;
                end
                else if (active)
                begin
                    refusal_next = trs_pkg::REF_STARTED;
                end
                else
                begin
                    action_next = trs_pkg::ACT_START_ALL;
                end
            end
            trs_pkg::CMD_STOP:
            begin
                action_next = trs_pkg::ACT_KILL_ALL;
                signal_next = stop_signal_reg;
            end
            trs_pkg::CMD_RESTART:
            begin
                action_next = trs_pkg::ACT_KILL_START;
                signal_next = stop_signal_reg;
            end
            trs_pkg::CMD_WORKER_ENDED:
            begin
                if (active && worker_ok)
                begin
                    if ((mode_reg == trs_pkg::ST_STARTING) && !end_settles)
                    begin
                        if (retry_ok)
                        begin
                            action_next = trs_pkg::ACT_KILL_START;
                            signal_next = trs_pkg::SIGKILL;
                        end
                    end
                    else if (restart_one)
                    begin
                        action_next = trs_pkg::ACT_START_ONE;
                        worker_next = worker_reg;
                    end
                end
            end
            trs_pkg::CMD_START_FAILED:
            begin
                if (mode_reg == trs_pkg::ST_STARTING)
                begin
                    action_next = trs_pkg::ACT_STOP_DEFAULT;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // state and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= trs_pkg::ST_STOPPED;
            tries_reg     <= 8'd0;
            elapsed_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg    <= mode_next;
                tries_reg   <= tries_next;
                elapsed_reg <= elapsed_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_state_reg   <= mode_next;
            res_action_reg  <= action_next;
            res_signal_reg  <= signal_next;
            res_worker_reg  <= worker_next;
            res_refusal_reg <= refusal_next;
            res_tries_reg   <= tries_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign group_state   = res_state_reg;
    assign action        = res_action_reg;
    assign action_signal = res_signal_reg;
    assign action_worker = res_worker_reg;
    assign refusal       = res_refusal_reg;
    assign tries_now     = res_tries_reg;

endmodule

`default_nettype wire

FILE: rtl/core/trs_checker.sv
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks on the task restart supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trs_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [2:0]                       command,
    input  wire logic [3:0]                       worker_index,
    input  wire logic                             exited_by_code,
    input  wire logic [7:0]                       exit_code,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [2:0]                       group_state,
    input  wire logic [2:0]                       action,
    input  wire logic [4:0]                       action_signal,
    input  wire logic [3:0]                       action_worker,
    input  wire logic [1:0]                       refusal,
    input  wire logic [7:0]                       tries_now,
    input  wire logic                             cfg_write,
    input  wire logic [trs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [trs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic out_held;

    assign out_held = out_valid && out_stall;

    // a stalled result stays put
    `ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_held, out_valid, "stalled result dropped")
    `ASSERT_NEXT(a_out_payload_hold, clk, rst_n, out_held, $stable(group_state) && $stable(action) && $stable(action_signal) && $stable(action_worker) && $stable(refusal) && $stable(tries_now), "stalled result changed")

    // only kill actions carry a signal
    `ASSERT_NOW(a_signal_only_on_kill, clk, rst_n, out_valid && (action_signal != 5'd0), (action == trs_pkg::ACT_KILL_ALL) || (action == trs_pkg::ACT_KILL_START), "signal without kill")

    // a refused start does nothing
    `ASSERT_NOW(a_refusal_no_action, clk, rst_n, out_valid && (refusal != trs_pkg::REF_ACCEPTED), action == trs_pkg::ACT_NONE, "refused start acted")

    // a fresh start leaves the group starting on its first try
    `ASSERT_NOW(a_start_all_first_try, clk, rst_n, out_valid && (action == trs_pkg::ACT_START_ALL), (tries_now == 8'd1) && (group_state == trs_pkg::ST_STARTING), "start all with bad state")

endmodule

bind task_restart_supervisor_top trs_checker u_trs_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for task_restart_supervisor_top. A driver feeds
// lifecycle events from a queue and a monitor checks each result against
// a cycle-free model of the group state, try count and tick count. The run
// walks through several register settings, the extremes among them.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [2:0] CMD_RESERVED_A      = 3'd6;
    localparam logic [2:0] CMD_RESERVED_B      = 3'd7;
    localparam logic [1:0] RESTART_MODE_UNUSED = 2'd3;
    localparam int         RESULT_LATENCY      = 4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] worker;
        logic       by_code;
        logic [7:0] code;
    } supervisor_cmd_t;

    typedef struct packed {
        trs_pkg::group_state_t state;
        trs_pkg::action_t      act;
        logic [4:0]            sig;
        logic [3:0]            worker;
        trs_pkg::refusal_t     refuse;
        logic [7:0]            tries;
    } action_result_t;

    typedef struct packed {
        logic [15:0]     settle;
        logic [7:0]      retries;
        logic [1:0]      mode;
        logic [4:0]      sig;
        logic [1:0]      count;
        logic [2:0][7:0] codes;
    } supervisor_cfg_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [3:0]  worker_index = '0;
    logic        exited_by_code = 1'b0;
    logic [7:0]  exit_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  group_state;
    logic [2:0]  action;
    logic [4:0]  action_signal;
    logic [3:0]  action_worker;
    logic [1:0]  refusal;
    logic [7:0]  tries_now;
    logic        cfg_write = 1'b0;
    logic [trs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    supervisor_cmd_t pending_cmds[$];
    action_result_t  expected_results[$];
    supervisor_cmd_t next_cmd;
    action_result_t  oldest_result;
    action_result_t  predicted;
    logic            in_took = 1'b0;
    int              send_gap = 0;
    int              stall_left = 0;
    bit              quiet = 1'b0;
    int              errors = 0;

    // model copy of the group
    supervisor_cfg_t       cfg_now;
    trs_pkg::group_state_t grp_state;
    logic [7:0]            grp_tries;
    logic [15:0]           grp_elapsed;

    task_restart_supervisor_top u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .worker_index   (worker_index),
        .exited_by_code (exited_by_code),
        .exit_code      (exit_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .group_state    (group_state),
        .action         (action),
        .action_signal  (action_signal),
        .action_worker  (action_worker),
        .refusal        (refusal),
        .tries_now      (tries_now),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit exit_is_expected(logic by_code, logic [7:0] code);
        int n;
        n = int'(cfg_now.count);
        if (n > trs_pkg::OK_CODES)
            n = trs_pkg::OK_CODES;
        if (n > 3)
            n = 3;
        if (!by_code)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (cfg_now.codes[i] == code)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void settle_if_due();
        if (grp_state == trs_pkg::ST_STARTING && grp_elapsed >= cfg_now.settle)
            grp_state = trs_pkg::ST_RUNNING;
    endfunction

    function automatic action_result_t advance_group(supervisor_cmd_t c);
        action_result_t r;
        bit live;
        r = '0;
        r.act = trs_pkg::ACT_NONE;
        r.refuse = trs_pkg::REF_ACCEPTED;
        live = (grp_state == trs_pkg::ST_STARTING || grp_state == trs_pkg::ST_RUNNING);
        case (c.cmd)
            trs_pkg::CMD_START:
            begin
                if (grp_state == trs_pkg::ST_ERROR)
                    r.refuse = trs_pkg::REF_IN_ERROR;
                else if (live)
                    r.refuse = trs_pkg::REF_STARTED;
                else
                begin
                    grp_tries = 8'd1;
                    grp_elapsed = '0;
                    grp_state = trs_pkg::ST_STARTING;
                    r.act = trs_pkg::ACT_START_ALL;
                end
            end
            trs_pkg::CMD_STOP:
            begin
                grp_state = trs_pkg::ST_STOPPED;
                grp_tries = '0;
                grp_elapsed = '0;
                r.act = trs_pkg::ACT_KILL_ALL;
                r.sig = cfg_now.sig;
            end
            trs_pkg::CMD_RESTART:
            begin
                grp_state = trs_pkg::ST_STARTING;
                grp_tries = 8'd1;
                grp_elapsed = '0;
                r.act = trs_pkg::ACT_KILL_START;
                r.sig = cfg_now.sig;
            end
            trs_pkg::CMD_TICK:
            begin
                if (live)
                begin
                    if (grp_elapsed != 16'hFFFF)
                        grp_elapsed = grp_elapsed + 16'd1;
                    settle_if_due();
                end
            end
            trs_pkg::CMD_WORKER_ENDED:
            begin
                if (live && int'(c.worker) < trs_pkg::MAX_WORKERS)
                begin
                    settle_if_due();
                    if (grp_state == trs_pkg::ST_STARTING)
                    begin
                        // early death: retry the whole group until out of tries
                        if (grp_tries < cfg_now.retries)
                        begin
                            if (grp_tries != 8'hFF)
                                grp_tries = grp_tries + 8'd1;
                            grp_elapsed = '0;
                            r.act = trs_pkg::ACT_KILL_START;
                            r.sig = trs_pkg::SIGKILL;
                        end
                        else
                            grp_state = trs_pkg::ST_FATAL;
                    end
                    else if (cfg_now.mode == trs_pkg::RESTART_ALWAYS ||
                             (cfg_now.mode == trs_pkg::RESTART_UNEXPECTED &&
                              !exit_is_expected(c.by_code, c.code)))
                    begin
                        r.act = trs_pkg::ACT_START_ONE;
                        r.worker = c.worker;
                    end
                    else
                        grp_state = trs_pkg::ST_EXITED;
                end
            end
            trs_pkg::CMD_START_FAILED:
            begin
                if (grp_state == trs_pkg::ST_STARTING)
                begin
                    grp_state = trs_pkg::ST_ERROR;
                    r.act = trs_pkg::ACT_STOP_DEFAULT;
                end
            end
            default:
            begin
            end
        endcase
        r.state = grp_state;
        r.tries = grp_tries;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: a new transaction only once the previous one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                command <= next_cmd.cmd;
                worker_index <= next_cmd.worker;
                exited_by_code <= next_cmd.by_code;
                exit_code <= next_cmd.code;
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 10);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: check results first, then predict the transaction taken now
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none outstanding, state %0d action %0d",
                             $time, group_state, action);
                    errors++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("group_state", 16'(oldest_result.state), 16'(group_state));
                    check_field("action", 16'(oldest_result.act), 16'(action));
                    check_field("action_signal", 16'(oldest_result.sig), 16'(action_signal));
                    check_field("action_worker", 16'(oldest_result.worker),
                                16'(action_worker));
                    check_field("refusal", 16'(oldest_result.refuse), 16'(refusal));
                    check_field("tries_now", 16'(oldest_result.tries), 16'(tries_now));
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted = advance_group({command, worker_index, exited_by_code, exit_code});
                expected_results = {expected_results, predicted};
            end
            in_took <= in_valid && !in_stall;
        end
    end

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] value, input int w);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        // junk above the register width must be dropped
        cfg_data <= 16'($urandom() << w) | value;
    endtask

    task automatic apply_settings(input supervisor_cfg_t s);
        put_reg(trs_pkg::CFG_SETTLE_TICKS, s.settle, 16);
        put_reg(trs_pkg::CFG_MAX_RETRIES, 16'(s.retries), 8);
        put_reg(trs_pkg::CFG_RESTART_MODE, 16'(s.mode), 2);
        put_reg(trs_pkg::CFG_STOP_SIGNAL, 16'(s.sig), 5);
        put_reg(trs_pkg::CFG_OK_CODE_COUNT, 16'(s.count), 2);
        put_reg(trs_pkg::CFG_OK_CODE_0, 16'(s.codes[0]), 8);
        put_reg(trs_pkg::CFG_OK_CODE_1, 16'(s.codes[1]), 8);
        put_reg(trs_pkg::CFG_OK_CODE_2, 16'(s.codes[2]), 8);
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_now = s;
    endtask

    function automatic supervisor_cfg_t random_settings();
        supervisor_cfg_t s;
        s.settle = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        s.retries = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        s.mode = 2'($urandom_range(0, 3));
        s.sig = 5'($urandom_range(1, 31));
        s.count = 2'($urandom_range(0, 3));
        s.codes = 24'($urandom);
        return s;
    endfunction

    task automatic queue_cmd(input logic [2:0] cmd, input logic [3:0] worker,
                             input logic by_code, input logic [7:0] code);
        supervisor_cmd_t c;
        c = {cmd, worker, by_code, code};
        pending_cmds = {pending_cmds, c};
    endtask

    // mostly start/tick/worker traffic so the group gets past starting
    task automatic queue_random(input int n);
        supervisor_cmd_t c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 14)
                c.cmd = trs_pkg::CMD_START;
            else if (r < 20)
                c.cmd = trs_pkg::CMD_STOP;
            else if (r < 26)
                c.cmd = trs_pkg::CMD_RESTART;
            else if (r < 60)
                c.cmd = trs_pkg::CMD_TICK;
            else if (r < 88)
                c.cmd = trs_pkg::CMD_WORKER_ENDED;
            else if (r < 95)
                c.cmd = trs_pkg::CMD_START_FAILED;
            else
                c.cmd = $urandom_range(0, 1) ? CMD_RESERVED_A : CMD_RESERVED_B;
            c.worker = 4'($urandom_range(0, 15));
            c.by_code = ($urandom_range(0, 3) != 0);
            c.code = $urandom_range(0, 1) ? cfg_now.codes[$urandom_range(0, 2)]
                                          : 8'($urandom);
            pending_cmds = {pending_cmds, c};
        end
    endtask

    // sampled at the rising edge so no driver update is still in flight
    task automatic wait_idle();
        @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(negedge clk);
    endtask

    initial
    begin
        supervisor_cfg_t s;
        cfg_now.settle = 16'd1;
        cfg_now.retries = 8'd3;
        cfg_now.mode = trs_pkg::RESTART_UNEXPECTED;
        cfg_now.sig = 5'd15;
        cfg_now.count = 2'd1;
        cfg_now.codes = '0;
        grp_state = trs_pkg::ST_STOPPED;
        grp_tries = '0;
        grp_elapsed = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults: ignored events, refusals, retries to fatal, error
        queue_cmd(trs_pkg::CMD_TICK, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd0, 1'b1, 8'd0);
        queue_cmd(trs_pkg::CMD_START_FAILED, 4'd0, 1'b0, 8'd0);
        queue_cmd(CMD_RESERVED_A, 4'd15, 1'b1, 8'd255);
        queue_cmd(CMD_RESERVED_B, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd3, 1'b1, 8'd0);
        queue_cmd(trs_pkg::CMD_TICK, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd15, 1'b1, 8'd255);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd7, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd0, 1'b1, 8'd0);
        queue_cmd(trs_pkg::CMD_TICK, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd9, 1'b1, 8'd170);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd6, 1'b0, 8'd85);
        queue_cmd(trs_pkg::CMD_WORKER_ENDED, 4'd15, 1'b1, 8'd1);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START_FAILED, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_START, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_TICK, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_RESTART, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_STOP, 4'd0, 1'b0, 8'd0);
        queue_cmd(trs_pkg::CMD_STOP, 4'd0, 1'b0, 8'd0);
        wait_idle();

        // no settle time, no retries, always restart, top signal
        s.settle = 16'd0;
        s.retries = 8'd0;
        s.mode = trs_pkg::RESTART_ALWAYS;
        s.sig = 5'd31;
        s.count = 2'd3;
        s.codes = {8'd170, 8'd0, 8'd255};
        apply_settings(s);
        queue_random(80);
        wait_idle();

        // longest settle, most retries, never restart, lowest signal
        s.settle = 16'hFFFF;
        s.retries = 8'd255;
        s.mode = trs_pkg::RESTART_NEVER;
        s.sig = 5'd1;
        s.count = 2'd0;
        s.codes = {8'd254, 8'd1, 8'd85};
        apply_settings(s);
        queue_random(80);
        wait_idle();

        // undefined policy value behaves as never restart
        s = random_settings();
        s.settle = 16'd2;
        s.retries = 8'd2;
        s.mode = RESTART_MODE_UNUSED;
        s.count = 2'd2;
        apply_settings(s);
        queue_random(80);
        wait_idle();

        repeat (5)
        begin
            apply_settings(random_settings());
            queue_random(90);
            wait_idle();
        end

        quiet = 1'b1;
        s = random_settings();
        s.mode = trs_pkg::RESTART_UNEXPECTED;
        s.count = 2'd3;
        apply_settings(s);
        queue_random(100);
        wait_idle();

        if (errors == 0)
            $display("task_restart_supervisor_top regression: pass");
        else
            $display("task_restart_supervisor_top regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("task_restart_supervisor_top regression: fail");
        $finish;
    end

endmodule
